// ----- rtl/i2cbm_pkg.sv -----
// Shared types and constants of the I2C bit-level master.
package i2cbm_pkg;

  // Widths of the word fields and of the configuration port.
  localparam int CFG_W       = 16;
  localparam int CFG_IDX_W   = 2;
  localparam int OP_W        = 3;
  localparam int BIT_INDEX_W = 4;
  localparam int STATUS_W    = 2;
  localparam int IN_DATA_W   = 16;
  localparam int OUT_DATA_W  = 16;

  // Register indexes of the configuration port.
  localparam logic [CFG_IDX_W-1:0] REG_LONG_DELAY    = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_SHORT_DELAY   = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_STRETCH_LIMIT = 2'd2;

  // Register values after reset.
  localparam logic [CFG_W-1:0] LONG_DELAY_RESET    = 16'd5;
  localparam logic [CFG_W-1:0] SHORT_DELAY_RESET   = 16'd3;
  localparam logic [CFG_W-1:0] STRETCH_LIMIT_RESET = 16'd10;

  // Command codes.
  localparam logic [OP_W-1:0] OP_TICK      = 3'd0;
  localparam logic [OP_W-1:0] OP_BUS_CLEAR = 3'd1;
  localparam logic [OP_W-1:0] OP_START     = 3'd2;
  localparam logic [OP_W-1:0] OP_STOP      = 3'd3;
  localparam logic [OP_W-1:0] OP_WRITE     = 3'd4;
  localparam logic [OP_W-1:0] OP_READ      = 3'd5;

  // Status codes.
  localparam logic [STATUS_W-1:0] ST_OK      = 2'd0;
  localparam logic [STATUS_W-1:0] ST_NACK    = 2'd1;
  localparam logic [STATUS_W-1:0] ST_TIMEOUT = 2'd2;

  typedef enum logic [4:0] {
    PH_IDLE,
    PH_CLR_HI, PH_CLR_LO,
    PH_ST_A, PH_ST_B, PH_ST_C, PH_ST_D,
    PH_SP_A, PH_SP_B, PH_SP_C,
    PH_W_LOW, PH_W_DATA, PH_W_HIGH, PH_W_WAIT,
    PH_W_ALOW, PH_W_AREL, PH_W_AHIGH, PH_W_AEND,
    PH_R_LOW, PH_R_HIGH, PH_R_WAIT,
    PH_R_ALOW, PH_R_ACK, PH_R_AHIGH, PH_R_END
  } phase_t;

  typedef struct packed {
    logic [CFG_W-1:0] long_delay_ticks;
    logic [CFG_W-1:0] short_delay_ticks;
    logic [CFG_W-1:0] stretch_timeout_ticks;
  } cfg_t;

  typedef struct packed {
    logic [STATUS_W-1:0] status;
    logic [7:0]          read_byte;
    logic                done_res;
    logic                busy_res;
    logic                sda_pull_low;
    logic                scl_pull_low;
  } result_t;

endpackage

// ----- rtl/i2cbm_cfg.sv -----
// Configuration registers of the I2C bit-level master.
module i2cbm_cfg (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               cfg_wen,
  input  logic [i2cbm_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [i2cbm_pkg::CFG_W-1:0]        cfg_data,
  output i2cbm_pkg::cfg_t                    cfg
);

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.long_delay_ticks      <= i2cbm_pkg::LONG_DELAY_RESET;
      cfg.short_delay_ticks     <= i2cbm_pkg::SHORT_DELAY_RESET;
      cfg.stretch_timeout_ticks <= i2cbm_pkg::STRETCH_LIMIT_RESET;
    end else if (cfg_wen) begin
      unique case (cfg_index)
        i2cbm_pkg::REG_LONG_DELAY:    cfg.long_delay_ticks      <= cfg_data;
        i2cbm_pkg::REG_SHORT_DELAY:   cfg.short_delay_ticks     <= cfg_data;
        i2cbm_pkg::REG_STRETCH_LIMIT: cfg.stretch_timeout_ticks <= cfg_data;
        default: ;  // writes to the unused index are dropped
      endcase
    end
  end

endmodule

// ----- rtl/i2cbm_seq.sv -----
// Phase sequencer of the I2C bit-level master: state registers and next-state logic.
module i2cbm_seq #(
  parameter int BUS_CLEAR_PULSES = 10,
  parameter int DELAY_WIDTH      = 16
) (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           step,
  input  logic [i2cbm_pkg::OP_W-1:0]     op,
  input  logic [7:0]                     write_byte,
  input  logic                           send_ack,
  input  logic                           scl_level,
  input  logic                           sda_level,
  input  i2cbm_pkg::cfg_t                cfg,
  output i2cbm_pkg::result_t             result
);

  localparam int CW = (DELAY_WIDTH > i2cbm_pkg::CFG_W) ? DELAY_WIDTH : i2cbm_pkg::CFG_W;
  localparam logic [CW-1:0] DELAY_MAX = CW'((64'd1 << DELAY_WIDTH) - 64'd1);
  localparam int BW = i2cbm_pkg::BIT_INDEX_W;
  localparam logic [BW:0] PULSES = (BW+1)'(BUS_CLEAR_PULSES);

  i2cbm_pkg::phase_t      phase, phase_next;
  logic [DELAY_WIDTH-1:0] delay_count, delay_count_next;
  logic [i2cbm_pkg::CFG_W-1:0] stretch_count, stretch_count_next;
  logic [BW-1:0]          bit_index, bit_index_next;
  logic [7:0]             shift_byte, shift_byte_next;
  logic                   ack_choice, ack_choice_next;
  logic                   scl_drive, scl_drive_next;
  logic                   sda_drive, sda_drive_next;

  logic [CW-1:0]          long_ext, short_ext;
  logic [DELAY_WIDTH-1:0] long_load, short_load;
  logic [i2cbm_pkg::CFG_W:0] stretch_inc;
  logic [BW:0]            bit_inc;

  // Delay loads, saturated to the counter width.
  assign long_ext   = CW'(cfg.long_delay_ticks);
  assign short_ext  = CW'(cfg.short_delay_ticks);
  assign long_load  = (long_ext > DELAY_MAX) ? DELAY_MAX[DELAY_WIDTH-1:0]
                                             : long_ext[DELAY_WIDTH-1:0];
  assign short_load = (short_ext > DELAY_MAX) ? DELAY_MAX[DELAY_WIDTH-1:0]
                                              : short_ext[DELAY_WIDTH-1:0];
  assign stretch_inc = {1'b0, stretch_count} + 1'b1;
  assign bit_inc     = {1'b0, bit_index} + 1'b1;

  always_comb begin
    i2cbm_pkg::phase_t ent_phase;
    logic ent;
    logic ent_scl;
    logic ent_sda;
    logic ent_long;
    ent       = 1'b0;
    ent_phase = i2cbm_pkg::PH_IDLE;
    ent_scl   = scl_drive;
    ent_sda   = sda_drive;
    ent_long  = 1'b1;

    phase_next         = phase;
    delay_count_next   = delay_count;
    stretch_count_next = stretch_count;
    bit_index_next     = bit_index;
    shift_byte_next    = shift_byte;
    ack_choice_next    = ack_choice;
    scl_drive_next     = scl_drive;
    sda_drive_next     = sda_drive;
    result             = '0;

    if (phase == i2cbm_pkg::PH_IDLE) begin
      if (op >= i2cbm_pkg::OP_BUS_CLEAR && op <= i2cbm_pkg::OP_READ) begin
        bit_index_next = '0;
        ent = 1'b1;
        case (op)
          i2cbm_pkg::OP_BUS_CLEAR: begin
            ent_phase = i2cbm_pkg::PH_CLR_HI; ent_scl = 1'b0; ent_sda = 1'b1;
          end
          i2cbm_pkg::OP_START: begin
            ent_phase = i2cbm_pkg::PH_ST_A; ent_sda = 1'b0;
          end
          i2cbm_pkg::OP_STOP: begin
            ent_phase = i2cbm_pkg::PH_SP_A; ent_sda = 1'b1;
          end
          i2cbm_pkg::OP_WRITE: begin
            shift_byte_next = write_byte;
            ent_phase = i2cbm_pkg::PH_W_LOW; ent_scl = 1'b1; ent_long = 1'b0;
          end
          default: begin
            shift_byte_next = '0;
            ack_choice_next = send_ack;
            ent_phase = i2cbm_pkg::PH_R_LOW; ent_scl = 1'b1;
          end
        endcase
      end
    end else if (phase == i2cbm_pkg::PH_W_WAIT || phase == i2cbm_pkg::PH_R_WAIT) begin
      if (scl_level) begin
        bit_index_next = bit_inc[BW-1:0];
        ent     = 1'b1;
        ent_scl = 1'b1;
        if (phase == i2cbm_pkg::PH_W_WAIT) begin
          shift_byte_next = {shift_byte[6:0], 1'b0};
          ent_long  = 1'b0;
          ent_phase = (bit_inc < (BW+1)'(8)) ? i2cbm_pkg::PH_W_LOW : i2cbm_pkg::PH_W_ALOW;
        end else begin
          // Bits arrive MSB first; the low three bits of the index select the bit.
          if (sda_level) begin
            shift_byte_next = shift_byte | (8'h80 >> bit_index[2:0]);
          end
          ent_phase = (bit_inc < (BW+1)'(8)) ? i2cbm_pkg::PH_R_LOW : i2cbm_pkg::PH_R_ALOW;
        end
      end else begin
        stretch_count_next = stretch_inc[i2cbm_pkg::CFG_W-1:0];
        if (stretch_inc >= {1'b0, cfg.stretch_timeout_ticks}) begin
          phase_next      = i2cbm_pkg::PH_IDLE;
          result.done_res = 1'b1;
          result.status   = i2cbm_pkg::ST_TIMEOUT;
        end
      end
    end else if (delay_count > DELAY_WIDTH'(1)) begin
      delay_count_next = delay_count - 1'b1;
    end else begin
      unique case (phase)
        i2cbm_pkg::PH_CLR_HI: begin
          ent = 1'b1; ent_phase = i2cbm_pkg::PH_CLR_LO; ent_scl = 1'b1;
        end
        i2cbm_pkg::PH_CLR_LO: begin
          bit_index_next = bit_inc[BW-1:0];
          if (bit_inc < PULSES) begin
            ent = 1'b1; ent_phase = i2cbm_pkg::PH_CLR_HI; ent_scl = 1'b0;
          end else begin
            scl_drive_next  = 1'b0;
            sda_drive_next  = 1'b0;
            phase_next      = i2cbm_pkg::PH_IDLE;
            result.done_res = 1'b1;
          end
        end
        i2cbm_pkg::PH_ST_A: begin
          ent = 1'b1; ent_phase = i2cbm_pkg::PH_ST_B; ent_scl = 1'b0;
        end
        i2cbm_pkg::PH_ST_B: begin
          ent = 1'b1; ent_phase = i2cbm_pkg::PH_ST_C; ent_sda = 1'b1;
        end
        i2cbm_pkg::PH_ST_C: begin
          ent = 1'b1; ent_phase = i2cbm_pkg::PH_ST_D; ent_scl = 1'b1;
        end
        i2cbm_pkg::PH_SP_A: begin
          ent = 1'b1; ent_phase = i2cbm_pkg::PH_SP_B; ent_scl = 1'b0; ent_long = 1'b0;
        end
        i2cbm_pkg::PH_SP_B: begin
          ent = 1'b1; ent_phase = i2cbm_pkg::PH_SP_C; ent_sda = 1'b0;
        end
        i2cbm_pkg::PH_W_LOW: begin
          ent = 1'b1; ent_phase = i2cbm_pkg::PH_W_DATA; ent_sda = ~shift_byte[7];
        end
        i2cbm_pkg::PH_W_DATA: begin
          ent = 1'b1; ent_phase = i2cbm_pkg::PH_W_HIGH; ent_scl = 1'b0;
        end
        i2cbm_pkg::PH_W_HIGH: begin
          phase_next         = i2cbm_pkg::PH_W_WAIT;
          stretch_count_next = '0;
        end
        i2cbm_pkg::PH_W_ALOW: begin
          ent = 1'b1; ent_phase = i2cbm_pkg::PH_W_AREL; ent_sda = 1'b0;
        end
        i2cbm_pkg::PH_W_AREL: begin
          ent = 1'b1; ent_phase = i2cbm_pkg::PH_W_AHIGH; ent_scl = 1'b0;
        end
        i2cbm_pkg::PH_W_AHIGH: begin
          // A high SDA sampled while SCL is high in the acknowledge bit means not acknowledged.
          ack_choice_next = sda_level;
          ent = 1'b1; ent_phase = i2cbm_pkg::PH_W_AEND; ent_scl = 1'b1;
        end
        i2cbm_pkg::PH_W_AEND: begin
          phase_next      = i2cbm_pkg::PH_IDLE;
          result.done_res = 1'b1;
          result.status   = ack_choice ? i2cbm_pkg::ST_NACK : i2cbm_pkg::ST_OK;
        end
        i2cbm_pkg::PH_R_LOW: begin
          ent = 1'b1; ent_phase = i2cbm_pkg::PH_R_HIGH; ent_scl = 1'b0;
        end
        i2cbm_pkg::PH_R_HIGH: begin
          phase_next         = i2cbm_pkg::PH_R_WAIT;
          stretch_count_next = '0;
        end
        i2cbm_pkg::PH_R_ALOW: begin
          ent = 1'b1; ent_phase = i2cbm_pkg::PH_R_ACK; ent_sda = ack_choice;
        end
        i2cbm_pkg::PH_R_ACK: begin
          ent = 1'b1; ent_phase = i2cbm_pkg::PH_R_AHIGH; ent_scl = 1'b0;
        end
        i2cbm_pkg::PH_R_AHIGH: begin
          ent = 1'b1; ent_phase = i2cbm_pkg::PH_R_END; ent_scl = 1'b1; ent_sda = 1'b0;
        end
        i2cbm_pkg::PH_R_END: begin
          phase_next       = i2cbm_pkg::PH_IDLE;
          result.done_res  = 1'b1;
          result.read_byte = shift_byte;
        end
        default: begin
          // End of a start or stop sequence, and any unused phase code.
          phase_next      = i2cbm_pkg::PH_IDLE;
          result.done_res = 1'b1;
        end
      endcase
    end

    if (ent) begin
      phase_next       = ent_phase;
      scl_drive_next   = ent_scl;
      sda_drive_next   = ent_sda;
      delay_count_next = ent_long ? long_load : short_load;
    end

    result.scl_pull_low = scl_drive_next;
    result.sda_pull_low = sda_drive_next;
    result.busy_res     = (phase_next != i2cbm_pkg::PH_IDLE);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase         <= i2cbm_pkg::PH_IDLE;
      delay_count   <= '0;
      stretch_count <= '0;
      bit_index     <= '0;
      shift_byte    <= '0;
      ack_choice    <= 1'b0;
      scl_drive     <= 1'b0;
      sda_drive     <= 1'b0;
    end else if (step) begin
      phase         <= phase_next;
      delay_count   <= delay_count_next;
      stretch_count <= stretch_count_next;
      bit_index     <= bit_index_next;
      shift_byte    <= shift_byte_next;
      ack_choice    <= ack_choice_next;
      scl_drive     <= scl_drive_next;
      sda_drive     <= sda_drive_next;
    end
  end

endmodule

// ----- rtl/i2cbm_out.sv -----
// Output register of the I2C bit-level master: holds one result word for the receiver.
module i2cbm_out (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                load,
  input  i2cbm_pkg::result_t                  result,
  output logic                                ready,
  output logic                                m_axis_tvalid,
  input  logic                                m_axis_tready,
  output logic [i2cbm_pkg::OUT_DATA_W-1:0]    m_axis_tdata
);

  localparam int RES_W = $bits(i2cbm_pkg::result_t);

  i2cbm_pkg::result_t held;

  // A new word may enter when the register is empty or is being emptied now.
  assign ready        = !m_axis_tvalid || m_axis_tready;
  assign m_axis_tdata = {{(i2cbm_pkg::OUT_DATA_W - RES_W){1'b0}}, held};

  always_ff @(posedge clk) begin
    if (rst) begin
      m_axis_tvalid <= 1'b0;
    end else if (load) begin
      m_axis_tvalid <= 1'b1;
    end else if (m_axis_tready) begin
      m_axis_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      held <= result;
    end
  end

endmodule

// ----- rtl/i2c_bit_level_master_unit.sv -----
// Top level of the I2C bit-level master: stream ports, configuration port and assertions.
//
// Each input word is one tick of the bus sequencer. tuser carries the command code
// (tick, bus clear, start, stop, write byte, read byte); tdata carries the byte to
// send, the acknowledge choice for a read and the sampled SCL and SDA levels. A
// command is taken only while the sequencer is idle; otherwise it counts as a plain
// tick. Every accepted word yields exactly one result word with the line drives
// (1 pulls the line low), busy, a done pulse, the received byte and the status.
// The result word appears on the master side in the cycle after its input word is
// accepted. A new input word is taken in every cycle in which the output register
// is empty or its word is being taken, so the sustained rate is one word per cycle;
// the single output register between the sequencer and the master side sets that.
// When the receiver stalls, the result word is held and s_axis_tready falls until
// it is taken; no sequencer state moves meanwhile.
// Synchronous reset returns the sequencer to idle with both lines released, empties
// the output register and loads all three configuration registers with defaults.
// The configuration port writes a register on every clock edge with cfg_wen high:
// index 0 long delay, 1 short delay, index 2 SCL stretch timeout; index 3 is ignored.
module i2c_bit_level_master_unit #(
  parameter int BUS_CLEAR_PULSES = 10,
  parameter int DELAY_WIDTH      = 16
) (
  input  logic                                clk,
  input  logic                                rst,
  // Input words.
  input  logic                                s_axis_tvalid,
  output logic                                s_axis_tready,
  // [7:0] write_byte, [8] send_ack, [9] scl_level, [10] sda_level, rest zero
  input  logic [i2cbm_pkg::IN_DATA_W-1:0]     s_axis_tdata,
  // [2:0] op
  input  logic [i2cbm_pkg::OP_W-1:0]          s_axis_tuser,
  // Result words.
  output logic                                m_axis_tvalid,
  input  logic                                m_axis_tready,
  // [0] scl_pull_low, [1] sda_pull_low, [2] busy_res, [3] done_res,
  // [11:4] read_byte, [13:12] status, rest zero
  output logic [i2cbm_pkg::OUT_DATA_W-1:0]    m_axis_tdata,
  // Configuration writes.
  input  logic                                cfg_wen,
  input  logic [i2cbm_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [i2cbm_pkg::CFG_W-1:0]         cfg_data
);

  i2cbm_pkg::cfg_t    cfg;
  i2cbm_pkg::result_t result;
  logic               step;

  assign step = s_axis_tvalid && s_axis_tready;

  i2cbm_cfg u_cfg (
    .clk       (clk),
    .rst       (rst),
    .cfg_wen   (cfg_wen),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cfg       (cfg)
  );

  i2cbm_seq #(
    .BUS_CLEAR_PULSES (BUS_CLEAR_PULSES),
    .DELAY_WIDTH      (DELAY_WIDTH)
  ) u_seq (
    .clk        (clk),
    .rst        (rst),
    .step       (step),
    .op         (s_axis_tuser),
    .write_byte (s_axis_tdata[7:0]),
    .send_ack   (s_axis_tdata[8]),
    .scl_level  (s_axis_tdata[9]),
    .sda_level  (s_axis_tdata[10]),
    .cfg        (cfg),
    .result     (result)
  );

  i2cbm_out u_out (
    .clk           (clk),
    .rst           (rst),
    .load          (step),
    .result        (result),
    .ready         (s_axis_tready),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
  );

  // A finished command leaves the sequencer idle.
  assert property (@(posedge clk) disable iff (rst)
    (m_axis_tvalid && m_axis_tdata[3]) |-> !m_axis_tdata[2])
    else $error("done reported while still busy");

  // Status and read data are only non-zero on a done word.
  assert property (@(posedge clk) disable iff (rst)
    (m_axis_tvalid && (m_axis_tdata[13:12] != i2cbm_pkg::ST_OK || m_axis_tdata[11:4] != 8'd0))
    |-> m_axis_tdata[3])
    else $error("status or read byte outside a done word");

  // Every accepted tick produces a result word in the next cycle.
  assert property (@(posedge clk) disable iff (rst)
    (s_axis_tvalid && s_axis_tready) |=> m_axis_tvalid)
    else $error("accepted word produced no result");

  // An empty output register never blocks the input side.
  assert property (@(posedge clk) disable iff (rst)
    !m_axis_tvalid |-> s_axis_tready)
    else $error("input stalled with an empty output register");

endmodule
